### src/rational_arithmetic_unit_core_macros.svh
// Assertion macros for the rational arithmetic unit.
// Define NO_ASSERTIONS to compile every check away.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock, off during reset.
`define RAU_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("rational unit check failed");
// Next-cycle implication, sampled on the rising clock, off during reset.
`define RAU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("rational unit check failed");
`else
`define RAU_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons)
`define RAU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif

`endif

### src/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package rau_pkg;

  localparam int WIDTH  = 16;
  localparam int DEN_W  = WIDTH - 1;
  localparam int PROD_W = 2 * WIDTH;
  localparam int CNT_W  = $clog2(PROD_W);

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef logic signed [WIDTH-1:0]  num_t;
  typedef logic        [DEN_W-1:0]  den_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic        [PROD_W-1:0] mag_t;
  typedef logic        [CNT_W-1:0]  cnt_t;

  // Largest magnitude a positive numerator or a denominator may have
  localparam mag_t POS_LIMIT = mag_t'((64'd1 << (WIDTH - 1)) - 64'd1);

endpackage

`default_nettype wire

### src/rau_req_if.sv
// Request channel of the rational arithmetic unit: operation and two fractions.
// Depends on rau_pkg.
`default_nettype none

interface rau_req_if;
  import rau_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  num_t  left_num;
  den_t  left_den;
  num_t  right_num;
  den_t  right_den;

  modport source (
    output valid, kind, left_num, left_den, right_num, right_den,
    input  ready
  );

  modport sink (
    input  valid, kind, left_num, left_den, right_num, right_den,
    output ready
  );
endinterface

`default_nettype wire

### src/rau_rsp_if.sv
// Result channel of the rational arithmetic unit: reduced fraction and flags.
// Depends on rau_pkg.
`default_nettype none

interface rau_rsp_if;
  import rau_pkg::*;

  logic valid;
  logic ready;
  num_t result_num;
  den_t result_den;
  logic is_less;
  logic is_equal;
  logic div_by_zero;
  logic overflow;

  modport source (
    output valid, result_num, result_den, is_less, is_equal, div_by_zero, overflow,
    input  ready
  );

  modport sink (
    input  valid, result_num, result_den, is_less, is_equal, div_by_zero, overflow,
    output ready
  );
endinterface

`default_nettype wire

### src/rational_arithmetic_unit_core.sv
// Rational arithmetic unit. Takes one request of two fractions and an operation
// (add, subtract, multiply, divide), returns the result reduced to lowest terms
// plus less-than and equal flags. The unit handles one request at a time: after
// acceptance it forms four products through one 16x16 multiplier, runs two setup
// steps, a binary gcd loop through one shared subtractor, and two 32-step
// restoring divisions by the gcd on the same subtractor, then loads the result
// register. Divide by zero skips the gcd and divisions. The result register lets
// the next request start while the previous result waits to be taken.
// Depends on rau_pkg, rau_req_if, rau_rsp_if and the macros header.
`default_nettype none

`include "rational_arithmetic_unit_core_macros.svh"

module rational_arithmetic_unit_core (
  input  wire logic  clk,
  input  wire logic  rst,
  rau_req_if.sink    req,
  rau_rsp_if.source  rsp
);
  import rau_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_PREP = 7'b0000100,
    S_ABS  = 7'b0001000,
    S_GCD  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state;
  cnt_t   cnt;
  cnt_t   k;
  kind_t  kind_r;
  num_t   ln, rn;
  den_t   ld, rd;
  prod_t  cross_l, cross_r, num_prod, den_prod;
  prod_t  num_val, den_val;
  logic   less, equal, dz, neg, div_den;
  mag_t   mag_n, mag_d, a, b, g, dq, rem, q_n;

  logic   out_valid;
  num_t   out_num;
  den_t   out_den;
  logic   out_less, out_equal, out_dz, out_ovf;

  // Shared multiplier
  num_t   mul_x, mul_y;
  prod_t  mul_p;

  // Shared subtractor
  mag_t            sub_x, sub_y;
  logic [PROD_W:0] sub_d;
  logic            borrow;
  logic            a_ge_b;
  mag_t            rem_sh;

  // Final result shaping
  logic   fin_neg, fin_ovf;
  num_t   fin_num;
  den_t   fin_den;
  num_t   q_low;

  // Pick multiplier operands per step: cross terms, numerators, denominators
  always_comb begin
    unique case (cnt[1:0])
      2'd0: begin
        mul_x = ln;
        mul_y = $signed({1'b0, rd});
      end
      2'd1: begin
        mul_x = rn;
        mul_y = $signed({1'b0, ld});
      end
      2'd2: begin
        mul_x = ln;
        mul_y = rn;
      end
      default: begin
        mul_x = $signed({1'b0, ld});
        mul_y = $signed({1'b0, rd});
      end
    endcase
    mul_p = mul_x * mul_y;
  end

  // Route the subtractor: larger minus smaller in gcd, remainder minus gcd in divide
  assign a_ge_b = (a >= b);
  assign rem_sh = {rem[PROD_W-2:0], dq[PROD_W-1]};

  always_comb begin
    sub_x = '0;
    sub_y = '0;
    if (state == S_GCD) begin
      sub_x = a_ge_b ? a : b;
      sub_y = a_ge_b ? b : a;
    end else if (state == S_DIV) begin
      sub_x = rem_sh;
      sub_y = g;
    end
    sub_d  = {1'b0, sub_x} - {1'b0, sub_y};
    borrow = sub_d[PROD_W];
  end

  // Apply sign and range check to the reduced quotients
  always_comb begin
    q_low   = num_t'(q_n[WIDTH-1:0]);
    fin_neg = neg && (q_n != '0);
    fin_ovf = (fin_neg ? (q_n > POS_LIMIT + mag_t'(1)) : (q_n > POS_LIMIT)) ||
              (dq > POS_LIMIT);
    fin_num = '0;
    fin_den = '0;
    if (!dz && !fin_ovf) begin
      fin_num = fin_neg ? -q_low : q_low;
      fin_den = dq[DEN_W-1:0];
    end
  end

  assign req.ready = (state == S_IDLE);

  assign rsp.valid       = out_valid;
  assign rsp.result_num  = out_num;
  assign rsp.result_den  = out_den;
  assign rsp.is_less     = out_less;
  assign rsp.is_equal    = out_equal;
  assign rsp.div_by_zero = out_dz;
  assign rsp.overflow    = out_ovf;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded in its place
      if (rsp.valid && rsp.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind_r <= req.kind;
            ln     <= req.left_num;
            ld     <= req.left_den;
            rn     <= req.right_num;
            rd     <= req.right_den;
            cnt    <= '0;
            state  <= S_MUL;
          end
        end

        // One product per cycle
        S_MUL: begin
          unique case (cnt[1:0])
            2'd0:    cross_l  <= mul_p;
            2'd1:    cross_r  <= mul_p;
            2'd2:    num_prod <= mul_p;
            default: den_prod <= mul_p;
          endcase
          cnt <= cnt + cnt_t'(1);
          if (cnt[1:0] == 2'd3) begin
            state <= S_PREP;
          end
        end

        // Form the unreduced fraction and compare the operands
        S_PREP: begin
          unique case (kind_r)
            KIND_ADD: num_val <= cross_l + cross_r;
            KIND_SUB: num_val <= cross_l - cross_r;
            KIND_MUL: num_val <= num_prod;
            KIND_DIV: num_val <= cross_l;
          endcase
          den_val <= (kind_r == KIND_DIV) ? cross_r : den_prod;
          less    <= (cross_l < cross_r);
          equal   <= (cross_l == cross_r);
          state   <= S_ABS;
        end

        // Split into sign and magnitudes, seed the gcd
        S_ABS: begin
          dz    <= (den_val == '0);
          neg   <= num_val[PROD_W-1] ^ den_val[PROD_W-1];
          mag_n <= num_val[PROD_W-1] ? mag_t'(-num_val) : mag_t'(num_val);
          mag_d <= den_val[PROD_W-1] ? mag_t'(-den_val) : mag_t'(den_val);
          a     <= num_val[PROD_W-1] ? mag_t'(-num_val) : mag_t'(num_val);
          b     <= den_val[PROD_W-1] ? mag_t'(-den_val) : mag_t'(den_val);
          k     <= '0;
          state <= (den_val == '0) ? S_FIN : S_GCD;
        end

        // Binary gcd, one step per cycle
        S_GCD: begin
          priority if (a == '0) begin
            g       <= b << k;
            dq      <= mag_n;
            rem     <= '0;
            cnt     <= '0;
            div_den <= 1'b0;
            state   <= S_DIV;
          end else if (b == '0) begin
            g       <= a << k;
            dq      <= mag_n;
            rem     <= '0;
            cnt     <= '0;
            div_den <= 1'b0;
            state   <= S_DIV;
          end else if (!a[0] && !b[0]) begin
            a <= a >> 1;
            b <= b >> 1;
            k <= k + cnt_t'(1);
          end else if (!a[0]) begin
            a <= a >> 1;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else if (a_ge_b) begin
            a <= sub_d[PROD_W-1:0];
          end else begin
            b <= sub_d[PROD_W-1:0];
          end
        end

        // Restoring division by the gcd, numerator first, then denominator
        S_DIV: begin
          if ((cnt == cnt_t'(PROD_W - 1)) && !div_den) begin
            q_n     <= {dq[PROD_W-2:0], !borrow};
            dq      <= mag_d;
            rem     <= '0;
            cnt     <= '0;
            div_den <= 1'b1;
          end else begin
            rem <= borrow ? rem_sh : sub_d[PROD_W-1:0];
            dq  <= {dq[PROD_W-2:0], !borrow};
            cnt <= cnt + cnt_t'(1);
            if (cnt == cnt_t'(PROD_W - 1)) begin
              state <= S_FIN;
            end
          end
        end

        // Load the result register once it is free
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_num   <= fin_num;
            out_den   <= fin_den;
            out_less  <= less;
            out_equal <= equal;
            out_dz    <= dz;
            out_ovf   <= !dz && fin_ovf;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `RAU_ASSERT_IMPLY(a_flags_exclusive, clk, rst, rsp.valid, !(rsp.div_by_zero && rsp.overflow))
  `RAU_ASSERT_IMPLY(a_error_zeroes, clk, rst, rsp.valid && (rsp.div_by_zero || rsp.overflow),
                    (rsp.result_num == '0) && (rsp.result_den == '0))
  `RAU_ASSERT_IMPLY(a_den_nonzero, clk, rst, rsp.valid && !rsp.div_by_zero && !rsp.overflow,
                    rsp.result_den != '0)
  `RAU_ASSERT_IMPLY(a_gcd_nonzero, clk, rst, state == S_DIV, g != '0)
  `RAU_ASSERT_NEXT(a_start_mul, clk, rst, req.valid && req.ready, state == S_MUL)

endmodule

`default_nettype wire

### tb/rational_arithmetic_unit_core_tb.sv
// Self-checking testbench for rational_arithmetic_unit_core: drives fraction requests,
// predicts each reduced result and its flags, and checks them in order.
// Depends on rau_pkg, rau_req_if, rau_rsp_if and the core.
module rational_arithmetic_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rau_pkg::*;

  localparam int  RST_CYCLES   = 7;
  localparam int  HOLD_CYCLES  = 600;
  localparam int  TAIL_CYCLES  = 250;
  localparam int  PHASE_ITEMS  = 360;
  localparam int  MAX_PRINTS   = 40;
  localparam longint LIMIT_CYCLES = 1_500_000;

  localparam int NUM_MAX = (1 << (WIDTH - 1)) - 1;
  localparam int NUM_MIN = -(1 << (WIDTH - 1));
  localparam int DEN_MAX = (1 << (WIDTH - 1)) - 1;
  localparam longint unsigned FIT_LIMIT = (64'd1 << (WIDTH - 1)) - 64'd1;

  typedef struct {
    kind_t kind;
    num_t  left_num;
    den_t  left_den;
    num_t  right_num;
    den_t  right_den;
  } ratio_req_t;

  typedef struct {
    num_t result_num;
    den_t result_den;
    logic is_less;
    logic is_equal;
    logic div_by_zero;
    logic overflow;
  } ratio_rsp_t;

  logic clk;
  logic rst;

  rau_req_if req_ch ();
  rau_rsp_if rsp_ch ();

  rational_arithmetic_unit_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ratio_req_t pending_reqs[$];
  ratio_rsp_t expected_ratios[$];

  ratio_req_t next_req;
  ratio_req_t seen_req;
  ratio_rsp_t seen_rsp;
  ratio_rsp_t want_rsp;

  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  bit     req_accepted   = 0;
  bit     hold_start     = 0;
  int     hold_left      = 0;
  int     n_offered      = 0;
  int     n_accepted     = 0;
  int     n_checked      = 0;
  int     mismatch_count = 0;
  int     kind_count[4]  = '{0, 0, 0, 0};
  int     n_dz           = 0;
  int     n_ovf          = 0;
  int     n_zero         = 0;
  longint cycle_count    = 0;

  // Free-running clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predict the reduced fraction and the comparison flags of one request
  function automatic ratio_rsp_t reduce_ratio(ratio_req_t r);
    longint ln, ld, rn, rd, cross_l, cross_r, num, den;
    longint unsigned mag, dm, a, b, t;
    bit neg;
    ratio_rsp_t e;
    ln = longint'(r.left_num);
    ld = longint'(r.left_den);
    rn = longint'(r.right_num);
    rd = longint'(r.right_den);
    cross_l = ln * rd;
    cross_r = rn * ld;
    case (r.kind)
      KIND_ADD: begin num = cross_l + cross_r; den = ld * rd; end
      KIND_SUB: begin num = cross_l - cross_r; den = ld * rd; end
      KIND_MUL: begin num = ln * rn;           den = ld * rd; end
      default:  begin num = cross_l;           den = ld * rn; end
    endcase
    e.result_num  = '0;
    e.result_den  = '0;
    e.is_less     = cross_l < cross_r;
    e.is_equal    = cross_l == cross_r;
    e.div_by_zero = 1'b0;
    e.overflow    = 1'b0;
    if (den == 0) begin
      e.div_by_zero = 1'b1;
    end else begin
      neg = (num < 0) != (den < 0);
      mag = (num < 0) ? longint'(-num) : longint'(num);
      dm  = (den < 0) ? longint'(-den) : longint'(den);
      // Euclid on the magnitudes
      a = mag;
      b = dm;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      mag = mag / a;
      dm  = dm / a;
      if (mag == 0) neg = 1'b0;
      if ((neg ? mag > FIT_LIMIT + 1 : mag > FIT_LIMIT) || dm > FIT_LIMIT) begin
        e.overflow = 1'b1;
      end else begin
        e.result_num = neg ? num_t'(-longint'(mag)) : num_t'(mag);
        e.result_den = den_t'(dm);
      end
    end
    return e;
  endfunction

  function automatic ratio_req_t make_req(kind_t k, int ln, int ld, int rn, int rd);
    ratio_req_t r;
    r.kind      = k;
    r.left_num  = num_t'(ln);
    r.left_den  = den_t'(ld);
    r.right_num = num_t'(rn);
    r.right_den = den_t'(rd);
    return r;
  endfunction

  function automatic num_t edge_num();
    case ($urandom_range(5))
      0:       return '0;
      1:       return num_t'(NUM_MIN);
      2:       return num_t'(NUM_MAX);
      3:       return num_t'(1);
      4:       return num_t'(-1);
      default: return num_t'($urandom);
    endcase
  endfunction

  function automatic den_t edge_den();
    case ($urandom_range(4))
      0:       return '0;
      1:       return den_t'(1);
      2:       return den_t'(DEN_MAX);
      default: return den_t'($urandom);
    endcase
  endfunction

  // Mix full-range operands with small ones that reduce and fit, equal values and edges
  function automatic ratio_req_t random_req();
    ratio_req_t r;
    int style;
    int scale;
    style  = $urandom_range(9);
    r.kind = kind_t'($urandom_range(3));
    case (style)
      0, 1, 2, 3: begin
        r.left_num  = num_t'($urandom);
        r.left_den  = den_t'($urandom);
        r.right_num = num_t'($urandom);
        r.right_den = den_t'($urandom);
      end
      4, 5, 6, 7: begin
        r.left_num  = num_t'(int'($urandom_range(128)) - 64);
        r.left_den  = den_t'($urandom_range(64, 1));
        r.right_num = num_t'(int'($urandom_range(128)) - 64);
        r.right_den = den_t'($urandom_range(64, 1));
      end
      8: begin
        scale       = $urandom_range(100, 1);
        r.left_num  = num_t'(int'($urandom_range(200)) - 100);
        r.left_den  = den_t'($urandom_range(300, 1));
        r.right_num = num_t'(int'(r.left_num) * scale);
        r.right_den = den_t'(int'(r.left_den) * scale);
      end
      default: begin
        r.left_num  = edge_num();
        r.left_den  = edge_den();
        r.right_num = edge_num();
        r.right_den = edge_den();
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string field, longint got, longint want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                n_checked, field, got, want));
  endtask

  // Hold until every queued request is accepted and every result is back
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || n_offered != n_accepted ||
           expected_ratios.size() != 0)
      @(posedge clk);
  endtask

  // Offer queued requests at the falling edge, idling at the phase rate
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_accepted) begin
      req_accepted = 1'b0;
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        req_ch.kind      <= next_req.kind;
        req_ch.left_num  <= next_req.left_num;
        req_ch.left_den  <= next_req.left_den;
        req_ch.right_num <= next_req.right_num;
        req_ch.right_den <= next_req.right_den;
        req_ch.valid     <= 1'b1;
        n_offered++;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at the phase rate, or fully during a hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Count down a long receiver hold-off
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left  = HOLD_CYCLES;
      hold_start = 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
    end
  end

  // Check results and record accepted requests at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_ratios.size());
        $display("rational_arithmetic_unit_core_tb failed");
        $finish;
      end else begin
        // compare a returned result with the oldest prediction
        if (rsp_ch.valid && rsp_ch.ready) begin
          seen_rsp.result_num  = rsp_ch.result_num;
          seen_rsp.result_den  = rsp_ch.result_den;
          seen_rsp.is_less     = rsp_ch.is_less;
          seen_rsp.is_equal    = rsp_ch.is_equal;
          seen_rsp.div_by_zero = rsp_ch.div_by_zero;
          seen_rsp.overflow    = rsp_ch.overflow;
          if (expected_ratios.size() == 0) begin
            report_mismatch("result returned with no request outstanding");
          end else begin
            want_rsp = expected_ratios.pop_front();
            check_field("result_num", longint'(seen_rsp.result_num),
                        longint'(want_rsp.result_num));
            check_field("result_den", longint'(seen_rsp.result_den),
                        longint'(want_rsp.result_den));
            check_field("is_less", longint'(seen_rsp.is_less),
                        longint'(want_rsp.is_less));
            check_field("is_equal", longint'(seen_rsp.is_equal),
                        longint'(want_rsp.is_equal));
            check_field("div_by_zero", longint'(seen_rsp.div_by_zero),
                        longint'(want_rsp.div_by_zero));
            check_field("overflow", longint'(seen_rsp.overflow),
                        longint'(want_rsp.overflow));
            n_checked++;
          end
        end
        // predict the result of an accepted request
        if (req_ch.valid && req_ch.ready) begin
          seen_req.kind      = req_ch.kind;
          seen_req.left_num  = req_ch.left_num;
          seen_req.left_den  = req_ch.left_den;
          seen_req.right_num = req_ch.right_num;
          seen_req.right_den = req_ch.right_den;
          want_rsp = reduce_ratio(seen_req);
          expected_ratios.push_back(want_rsp);
          kind_count[seen_req.kind]++;
          if (want_rsp.div_by_zero) n_dz++;
          if (want_rsp.overflow) n_ovf++;
          if (!want_rsp.div_by_zero && !want_rsp.overflow && want_rsp.result_num == 0)
            n_zero++;
          req_accepted = 1'b1;
          n_accepted++;
        end
      end
    end
  end

  // Directed requests, then random phases with different idling
  initial begin
    int send_pct[4];
    int recv_pct[4];
    send_pct = '{0, 71, 0, 36};
    recv_pct = '{0, 0, 71, 36};
    clk              = 1'b0;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.kind      = KIND_ADD;
    req_ch.left_num  = '0;
    req_ch.left_den  = '0;
    req_ch.right_num = '0;
    req_ch.right_den = '0;
    rsp_ch.ready     = 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // plain sums and products, zero results, divide by zero and zero denominators
    pending_reqs.push_back(make_req(KIND_ADD, 1, 2, 1, 3));
    pending_reqs.push_back(make_req(KIND_SUB, 1, 2, 1, 2));
    pending_reqs.push_back(make_req(KIND_ADD, 3, 4, -3, 4));
    pending_reqs.push_back(make_req(KIND_MUL, 2, 3, 3, 2));
    pending_reqs.push_back(make_req(KIND_DIV, 1, 2, 0, 5));
    pending_reqs.push_back(make_req(KIND_ADD, 1, 0, 1, 1));
    pending_reqs.push_back(make_req(KIND_MUL, 5, 3, 2, 0));
    pending_reqs.push_back(make_req(KIND_DIV, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(KIND_DIV, 7, 1, 3, 0));
    pending_reqs.push_back(make_req(KIND_SUB, 0, 1, 0, DEN_MAX));
    pending_reqs.push_back(make_req(KIND_DIV, 6, 35, -4, 21));
    pending_reqs.push_back(make_req(KIND_ADD, -1, 1, -1, 1));
    pending_reqs.push_back(make_req(KIND_DIV, -1, DEN_MAX, 1, DEN_MAX));
    pending_reqs.push_back(make_req(KIND_ADD, NUM_MAX, 2, 1, 2));
    // extremes of the fields, overflow on either side and on the denominator
    pending_reqs.push_back(make_req(KIND_DIV, NUM_MIN, 1, -1, 1));
    pending_reqs.push_back(make_req(KIND_MUL, NUM_MIN, 1, 1, 1));
    pending_reqs.push_back(make_req(KIND_MUL, NUM_MAX, 1, NUM_MAX, 1));
    pending_reqs.push_back(make_req(KIND_MUL, 1, DEN_MAX, 1, DEN_MAX));
    pending_reqs.push_back(make_req(KIND_ADD, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX));
    pending_reqs.push_back(make_req(KIND_SUB, NUM_MIN, 1, NUM_MAX, 1));
    pending_reqs.push_back(make_req(KIND_SUB, NUM_MAX, 1, NUM_MIN, 1));
    pending_reqs.push_back(make_req(KIND_MUL, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX));
    pending_reqs.push_back(make_req(KIND_DIV, NUM_MAX, 1, NUM_MAX, 1));
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      @(negedge clk);
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      // block the result side for a long stretch while requests keep coming
      if (p == 0) hold_start = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) pending_reqs.push_back(random_req());
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("requests: %0d add, %0d sub, %0d mul, %0d div; %0d results checked",
             kind_count[KIND_ADD], kind_count[KIND_SUB], kind_count[KIND_MUL],
             kind_count[KIND_DIV], n_checked);
    $display("outcomes: %0d divide-by-zero, %0d overflow, %0d zero; %0d mismatches",
             n_dz, n_ovf, n_zero, mismatch_count);
    if (mismatch_count == 0) begin
      $display("rational_arithmetic_unit_core_tb passed");
    end else begin
      $display("rational_arithmetic_unit_core_tb failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/rau_pkg.sv
src/rau_req_if.sv
src/rau_rsp_if.sv
src/rational_arithmetic_unit_core.sv
tb/rational_arithmetic_unit_core_tb.sv
